FILE: sv/slps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slps_pkg
// Shared types and constants of the status LED pattern sequencer.
// ----------------------------------------------------------------------------
package slps_pkg;

   localparam int LED_COUNT  = 4;
   localparam int DRIVEN     = 4;
   localparam int IDX_W      = 2;
   localparam int NUM_FLAGS  = 11;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;
   localparam int LEVEL_W    = 8;

   // request flag positions in req_tdata
   localparam int FLAG_INIT  = 0;
   localparam int FLAG_TRIM  = 1;
   localparam int FLAG_ESC   = 2;
   localparam int FLAG_RFS   = 3;
   localparam int FLAG_BFS   = 4;
   localparam int FLAG_GFS   = 5;
   localparam int FLAG_GG    = 6;
   localparam int FLAG_BG    = 7;
   localparam int FLAG_EB    = 8;
   localparam int FLAG_ARMED = 9;
   localparam int FLAG_USB   = 10;

   // register indexes
   localparam logic CSR_BRIGHT = 1'b0;
   localparam logic CSR_DIM    = 1'b1;

   localparam logic [2:0] PRESCALE_LAST = 3'd4;
   localparam logic [3:0] STEP_LAST     = 4'd9;
   localparam logic [3:0] STEP_FAIL_ALT = 4'd5;

   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_RGB   = 2'd1;
   localparam logic [1:0] MODE_MACRO = 2'd2;

   localparam logic [1:0] MAC_WHITE   = 2'd0;
   localparam logic [1:0] MAC_RED     = 2'd1;
   localparam logic [1:0] MAC_RESET   = 2'd2;
   localparam logic [1:0] MAC_BREATHE = 2'd3;

   localparam logic [2:0] STAGE_NONE        = 3'd0;
   localparam logic [2:0] STAGE_INIT        = 3'd1;
   localparam logic [2:0] STAGE_TRIM        = 3'd2;
   localparam logic [2:0] STAGE_FAIL        = 3'd3;
   localparam logic [2:0] STAGE_IDLE_COLOUR = 3'd4;
   localparam logic [2:0] STAGE_IDLE_RUN    = 3'd5;

   localparam logic [IDX_W-1:0] BACK_LEFT   = 2'd0;
   localparam logic [IDX_W-1:0] BACK_RIGHT  = 2'd1;
   localparam logic [IDX_W-1:0] FRONT_RIGHT = 2'd2;
   localparam logic [IDX_W-1:0] FRONT_LEFT  = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic [1:0]         macro;
   } led_rec_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic fire;
      logic pending_any;
      logic pending_last;
      logic out_free;
   } status_type;

endpackage

FILE: sv/status_led_pattern_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_led_pattern_sequencer
// Turns a stream of status requests into LED commands for four status LEDs.
// ----------------------------------------------------------------------------
// A request that does not advance the pattern (four of every five) is taken
// in the idle state and gives no command. Every fifth request goes from the
// idle state through an evaluation state to a send state, which gives one
// command per changed LED, or none when no LED changed; the commands leave
// one per cycle while rsp_tready stays high, through the output register,
// in LED index order, the last one of the request marked with rsp_tlast.
// The next request is taken once the final command is in the output
// register, or once the send state finds that no LED changed.
module status_led_pattern_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   // initialising, trim_store, motor_cal, radio_failsafe,
   // battery_failsafe, gps_failsafe, gps_glitch, baro_glitch,
   // estimator_bad, armed_flag, usb_present, zero fill
   input  logic [slps_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // led_index, red_level, green_level, blue_level, macro_code, zero fill
   output logic [slps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // is_macro
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_wr_en,
   input  logic                            csr_index,
   input  logic [slps_pkg::LEVEL_W-1:0]    csr_wdata
);
   import slps_pkg::*;

   cmd_type    cmd;
   status_type status;

   slps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   slps_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: sv/slps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slps_ctrl
// Sequencer: takes requests, evaluates the pattern on every fifth, then
// hands the changed LED commands to the output register one at a time.
// ----------------------------------------------------------------------------
module slps_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  slps_pkg::status_type status,
   output slps_pkg::cmd_type    cmd
);
   import slps_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_SEND = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               if (status.fire) begin
                  state_in = S_EVAL;
               end
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_SEND;
         end
         S_SEND: begin
            if (!status.pending_any) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.load = 1'b1;
               if (status.pending_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/slps_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slps_datapath
// Prescaler, pattern step, stage tracking, per-LED sent records, target
// evaluation and the result output register.
// ----------------------------------------------------------------------------
module slps_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  slps_pkg::cmd_type                 cmd,
   output slps_pkg::status_type              status,
   input  logic [slps_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [slps_pkg::LEVEL_W-1:0]      csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [slps_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import slps_pkg::*;

   logic [LEVEL_W-1:0]   bright_ff;
   logic [LEVEL_W-1:0]   dim_ff;
   logic [NUM_FLAGS-1:0] flags_ff;
   logic [2:0]           prescale_ff;
   logic [3:0]           step_ff;
   logic [3:0]           step_in;
   logic [2:0]           stage_ff;
   logic [2:0]           stage_in;
   led_rec_type          sent_ff [LED_COUNT];
   led_rec_type          tgt_ff  [DRIVEN];
   led_rec_type          tgt_in  [DRIVEN];
   logic [DRIVEN-1:0]    pending_ff;
   logic [DRIVEN-1:0]    changed;
   logic [DRIVEN-1:0]    sel_onehot;
   logic [IDX_W-1:0]     sel_idx;
   logic [LEVEL_W-1:0]   lvl;
   logic [LEVEL_W-1:0]   cr;
   logic [LEVEL_W-1:0]   cg;
   logic [LEVEL_W-1:0]   cb;
   logic                 any_fail;
   logic                 rsp_valid_ff;
   led_rec_type          out_rec;
   logic [IDX_W-1:0]     out_idx_ff;
   logic [LEVEL_W-1:0]   out_red_ff;
   logic [LEVEL_W-1:0]   out_green_ff;
   logic [LEVEL_W-1:0]   out_blue_ff;
   logic [1:0]           out_macro_ff;
   logic                 out_is_macro_ff;
   logic                 out_last_ff;

   function automatic led_rec_type set_rgb(led_rec_type base, logic [LEVEL_W-1:0] r,
                                           logic [LEVEL_W-1:0] g, logic [LEVEL_W-1:0] b);
      led_rec_type rec;
      rec       = base;
      rec.mode  = MODE_RGB;
      rec.red   = r;
      rec.green = g;
      rec.blue  = b;
      return rec;
   endfunction

   function automatic led_rec_type apply_macro(led_rec_type base, logic [1:0] m);
      led_rec_type rec;
      rec       = base;
      rec.mode  = MODE_MACRO;
      rec.macro = m;
      return rec;
   endfunction

   // pattern evaluation
   always_comb begin
      step_in  = (step_ff >= STEP_LAST) ? 4'd0 : step_ff + 4'd1;
      lvl      = flags_ff[FLAG_USB] ? dim_ff : bright_ff;
      stage_in = stage_ff;
      cr       = '0;
      cg       = '0;
      cb       = '0;
      any_fail = flags_ff[FLAG_RFS] | flags_ff[FLAG_BFS] | flags_ff[FLAG_GFS]
               | flags_ff[FLAG_GG] | flags_ff[FLAG_BG] | flags_ff[FLAG_EB];
      for (int i = 0; i < DRIVEN; i++) begin
         tgt_in[i] = sent_ff[i];
      end
      priority if (flags_ff[FLAG_INIT]) begin
         if (step_in[0]) begin
            tgt_in[FRONT_LEFT]  = set_rgb(sent_ff[FRONT_LEFT], lvl, lvl, lvl);
            tgt_in[BACK_LEFT]   = set_rgb(sent_ff[BACK_LEFT], lvl, '0, '0);
            tgt_in[FRONT_RIGHT] = set_rgb(sent_ff[FRONT_RIGHT], '0, '0, '0);
            tgt_in[BACK_RIGHT]  = set_rgb(sent_ff[BACK_RIGHT], '0, '0, '0);
         end else begin
            tgt_in[FRONT_LEFT]  = set_rgb(sent_ff[FRONT_LEFT], '0, '0, '0);
            tgt_in[BACK_LEFT]   = set_rgb(sent_ff[BACK_LEFT], '0, '0, '0);
            tgt_in[FRONT_RIGHT] = set_rgb(sent_ff[FRONT_RIGHT], lvl, lvl, lvl);
            tgt_in[BACK_RIGHT]  = set_rgb(sent_ff[BACK_RIGHT], lvl, '0, '0);
         end
         stage_in = STAGE_INIT;
      end else if (flags_ff[FLAG_TRIM] || flags_ff[FLAG_ESC]) begin
         unique case (step_in)
            4'd0, 4'd3, 4'd6: cr = lvl;
            4'd1, 4'd4, 4'd7: cb = lvl;
            4'd2, 4'd5, 4'd8: cg = lvl;
            default: begin
               cr = '0;
            end
         endcase
         for (int i = 0; i < DRIVEN; i++) begin
            tgt_in[i] = set_rgb(sent_ff[i], cr, cg, cb);
         end
         stage_in = STAGE_TRIM;
      end else if (any_fail) begin
         priority if (step_in < STEP_FAIL_ALT) begin
            cr = lvl;
            cg = lvl;
         end else if (flags_ff[FLAG_GFS] || flags_ff[FLAG_GG]) begin
            cb = lvl;
         end else if (flags_ff[FLAG_BG]) begin
            cr = lvl;
            cb = lvl;
         end else if (flags_ff[FLAG_EB]) begin
            cr = lvl;
         end else begin
            cr = '0;
         end
         for (int i = 0; i < DRIVEN; i++) begin
            tgt_in[i] = set_rgb(sent_ff[i], cr, cg, cb);
         end
         stage_in = STAGE_FAIL;
      end else if (stage_ff < STAGE_IDLE_COLOUR) begin
         tgt_in[FRONT_LEFT]  = apply_macro(sent_ff[FRONT_LEFT], MAC_WHITE);
         tgt_in[FRONT_RIGHT] = apply_macro(sent_ff[FRONT_RIGHT], MAC_WHITE);
         tgt_in[BACK_LEFT]   = apply_macro(sent_ff[BACK_LEFT], MAC_RED);
         tgt_in[BACK_RIGHT]  = apply_macro(sent_ff[BACK_RIGHT], MAC_RED);
         stage_in = STAGE_IDLE_COLOUR;
      end else begin
         for (int i = 0; i < DRIVEN; i++) begin
            tgt_in[i] = apply_macro(sent_ff[i],
                                    flags_ff[FLAG_ARMED] ? MAC_RESET : MAC_BREATHE);
         end
         stage_in = STAGE_IDLE_RUN;
      end
      for (int i = 0; i < DRIVEN; i++) begin
         changed[i] = (tgt_in[i] != sent_ff[i]);
      end
   end

   // lowest pending led goes next
   always_comb begin
      sel_idx    = '0;
      sel_onehot = '0;
      for (int i = DRIVEN - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            sel_idx    = IDX_W'(i);
            sel_onehot = DRIVEN'(1) << i;
         end
      end
      out_rec = tgt_ff[sel_idx];
   end

   assign status.fire         = (prescale_ff == PRESCALE_LAST);
   assign status.pending_any  = |pending_ff;
   assign status.pending_last = ((pending_ff & ~sel_onehot) == '0);
   assign status.out_free     = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff    <= 8'd255;
         dim_ff       <= 8'd64;
         prescale_ff  <= '0;
         step_ff      <= '0;
         stage_ff     <= STAGE_NONE;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LED_COUNT; i++) begin
            sent_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_BRIGHT: bright_ff <= csr_wdata;
               CSR_DIM:    dim_ff    <= csr_wdata;
               default: begin
                  bright_ff <= bright_ff;
               end
            endcase
         end
         if (cmd.capture) begin
            prescale_ff <= status.fire ? 3'd0 : prescale_ff + 3'd1;
         end
         if (cmd.eval) begin
            step_ff    <= step_in;
            stage_ff   <= stage_in;
            pending_ff <= changed;
            for (int i = 0; i < DRIVEN; i++) begin
               sent_ff[i] <= tgt_in[i];
            end
         end else if (cmd.load) begin
            pending_ff <= pending_ff & ~sel_onehot;
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         flags_ff <= req_tdata[NUM_FLAGS-1:0];
      end
      if (cmd.eval) begin
         for (int i = 0; i < DRIVEN; i++) begin
            tgt_ff[i] <= tgt_in[i];
         end
      end
      if (cmd.load) begin
         out_idx_ff      <= sel_idx;
         out_is_macro_ff <= (out_rec.mode == MODE_MACRO);
         out_last_ff     <= status.pending_last;
         if (out_rec.mode == MODE_MACRO) begin
            out_red_ff   <= '0;
            out_green_ff <= '0;
            out_blue_ff  <= '0;
            out_macro_ff <= out_rec.macro;
         end else begin
            out_red_ff   <= out_rec.red;
            out_green_ff <= out_rec.green;
            out_blue_ff  <= out_rec.blue;
            out_macro_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_is_macro_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {4'd0, out_macro_ff, out_blue_ff, out_green_ff, out_red_ff,
                        out_idx_ff};

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_tready))
      else $error("command loaded over a waiting result");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid_ff)
      else $error("loaded command not presented");

   a_prescale_range: assert property (@(posedge clock) disable iff (reset)
      prescale_ff <= PRESCALE_LAST)
      else $error("prescaler out of range");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_LAST)
      else $error("pattern step out of range");

   a_pending_only_after_eval: assert property (@(posedge clock) disable iff (reset)
      (pending_ff != $past(pending_ff)) |-> ($past(cmd.eval) || $past(cmd.load)))
      else $error("pending mask changed without eval or load");

endmodule
